// ===== hw/rtl/lfsr_key_xor_cipher_top_assert.svh =====
// ----------------------------------------------------------------------------
// lfsr_key_xor_cipher_top_assert.svh
// Assertion macros shared by the cipher RTL. Each macro expects signals
// named clk and arst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef LFSR_KEY_XOR_CIPHER_TOP_ASSERT_SVH
`define LFSR_KEY_XOR_CIPHER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LKXC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LKXC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/lkxc_pkg.sv =====
// ----------------------------------------------------------------------------
// lkxc_pkg
// Shared constants and controller/datapath interface types for the cipher.
// ----------------------------------------------------------------------------
package lkxc_pkg;

	localparam int LFSR_WIDTH_DEF = 8;
	localparam int DATA_W         = 8;
	localparam int KEY_W          = 32;
	localparam int CFG_DATA_W     = 32;
	localparam int CFG_IDX_W      = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_TAP_MASK   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED_VALUE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MSG_LEN    = 2'd2;

	// Configuration reset values.
	localparam logic [7:0]            TAP_RESET  = 8'd10;
	localparam logic [7:0]            SEED_RESET = 8'd1;
	localparam logic [CFG_DATA_W-1:0] LEN_RESET  = 32'd1;

	typedef struct packed {
		logic load;
		logic step;
		logic accept;
	} ctrl_cmd_t;

	typedef struct packed {
		logic last_step;
	} dp_status_t;

endpackage

// ===== hw/rtl/lkxc_dp.sv =====
// ----------------------------------------------------------------------------
// lkxc_dp
// Datapath: configuration registers, LFSR key generator, byte position
// counter and the registered XOR output.
// ----------------------------------------------------------------------------
module lkxc_dp #(
	parameter int LFSR_WIDTH = lkxc_pkg::LFSR_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lkxc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lkxc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  lkxc_pkg::ctrl_cmd_t                cmd,
	output lkxc_pkg::dp_status_t               status,
	input  logic [lkxc_pkg::DATA_W-1:0]        data_in,
	output logic [lkxc_pkg::DATA_W-1:0]        data_out
);
	import lkxc_pkg::*;

	localparam int DEG_W = $clog2(LFSR_WIDTH + 1);
	localparam int CNT_W = LFSR_WIDTH + 1;

	// Configuration registers; only the low LFSR_WIDTH bits of taps and seed matter.
	logic [LFSR_WIDTH-1:0] tap_q;
	logic [LFSR_WIDTH-1:0] seed_q;
	logic [KEY_W-1:0]      msg_len_q;

	// Key generator state.
	logic [LFSR_WIDTH-1:0] taps_run_q;
	logic [LFSR_WIDTH-1:0] ins_q;
	logic [LFSR_WIDTH-1:0] lfsr_q;
	logic [CNT_W-1:0]      last_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [KEY_W-1:0]      key_q;

	logic [KEY_W-1:0]      pos_q;
	logic [DATA_W-1:0]     data_out_q;

	logic [DEG_W-1:0]      degree;
	logic [LFSR_WIDTH-1:0] low_mask;
	logic [LFSR_WIDTH-1:0] ins_pos;
	logic [LFSR_WIDTH-1:0] seed_ld;
	logic [CNT_W-1:0]      last_ld;
	logic                  fb;

	logic [KEY_W:0]        len_w;
	logic [KEY_W-1:0]      p_cur;
	logic [KEY_W:0]        p_inc;
	logic [KEY_W-1:0]      pos_nxt;
	logic                  in_full;
	logic [1:0]            sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q     <= TAP_RESET[LFSR_WIDTH-1:0];
			seed_q    <= SEED_RESET[LFSR_WIDTH-1:0];
			msg_len_q <= LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TAP_MASK:   tap_q     <= cfg_data[LFSR_WIDTH-1:0];
				CFG_SEED_VALUE: seed_q    <= cfg_data[LFSR_WIDTH-1:0];
				CFG_MSG_LEN:    msg_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Degree, the low mask below it and the feedback insertion point.
	always_comb begin
		degree = '0;
		for (int i = 0; i < LFSR_WIDTH; i++) begin
			if (tap_q[i]) begin
				degree = DEG_W'(i + 1);
			end
		end
		for (int i = 0; i < LFSR_WIDTH; i++) begin
			low_mask[i] = (DEG_W'(i) < degree);
			ins_pos[i]  = (DEG_W'(i + 1) == degree);
		end
		// A seed with bits at or above the degree is replaced by the taps.
		seed_ld = ((seed_q & ~low_mask) != '0) ? tap_q : seed_q;
		last_ld = CNT_W'((32'd1 << degree) - 32'd1);
	end

	assign fb = ^(lfsr_q & taps_run_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			taps_run_q <= tap_q;
			ins_q      <= ins_pos;
			last_q     <= last_ld;
			lfsr_q     <= seed_ld;
			key_q      <= {{(KEY_W - LFSR_WIDTH){1'b0}}, seed_ld};
		end else if (cmd.step) begin
			lfsr_q <= {1'b0, lfsr_q[LFSR_WIDTH-1:1]} | (fb ? ins_q : '0);
			key_q  <= {key_q[KEY_W-2:0], lfsr_q[0]};
		end
	end

	assign status.last_step = (cnt_q == last_q);

	// A length of zero stands for 2^32.
	always_comb begin
		len_w   = {(msg_len_q == '0), msg_len_q};
		p_cur   = ({1'b0, pos_q} >= len_w) ? '0 : pos_q;
		p_inc   = {1'b0, p_cur} + (KEY_W + 1)'(1);
		pos_nxt = (p_inc >= len_w) ? '0 : p_inc[KEY_W-1:0];
		in_full = ({1'b0, p_cur[KEY_W-1:2]} < len_w[KEY_W:2]);
		if (in_full) begin
			sel = p_cur[1:0];
		end else if (len_w[1:0] == 2'd3) begin
			case (p_cur[1:0])
				2'd0:    sel = 2'd1;
				2'd1:    sel = 2'd2;
				default: sel = 2'd0;
			endcase
		end else begin
			sel = {1'b0, p_cur[0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.accept) begin
			pos_q <= pos_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			data_out_q <= data_in ^ key_q[8*sel +: DATA_W];
		end
	end

	assign data_out = data_out_q;

endmodule

// ===== hw/rtl/lkxc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lkxc_ctrl
// Controller: sequences key derivation on the first item and runs the
// input and output handshakes.
// ----------------------------------------------------------------------------
`include "lfsr_key_xor_cipher_top_assert.svh"

module lkxc_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	output logic                           out_valid,
	input  logic                           out_stall,
	input  logic                           cfg_we,
	input  logic [lkxc_pkg::CFG_IDX_W-1:0] cfg_index,
	output lkxc_pkg::ctrl_cmd_t            cmd,
	input  lkxc_pkg::dp_status_t           status
);
	import lkxc_pkg::*;

	typedef enum logic [3:0] {
		ST_WAIT = 4'b0001,
		ST_LOAD = 4'b0010,
		ST_STEP = 4'b0100,
		ST_RUN  = 4'b1000
	} state_t;

	state_t st_q;
	state_t st_d;
	logic   out_valid_q;
	logic   restart;
	logic   room;

	// A taps or seed write during derivation restarts it with the new values.
	assign restart = cfg_we && (cfg_index == CFG_TAP_MASK || cfg_index == CFG_SEED_VALUE);
	assign room    = !out_valid_q || !out_stall;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_WAIT: begin
				if (in_valid) begin
					st_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				st_d = restart ? ST_LOAD : ST_STEP;
			end
			ST_STEP: begin
				if (restart) begin
					st_d = ST_LOAD;
				end else if (status.last_step) begin
					st_d = ST_RUN;
				end
			end
			ST_RUN: st_d = ST_RUN;
			default: st_d = ST_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_WAIT;
		end else begin
			st_q <= st_d;
		end
	end

	assign cmd.load   = (st_q == ST_LOAD);
	assign cmd.step   = (st_q == ST_STEP);
	assign cmd.accept = (st_q == ST_RUN) && in_valid && room;
	assign in_stall   = !((st_q == ST_RUN) && room);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`LKXC_ASSERT_NEXT(a_accept_fills_out, cmd.accept, out_valid_q, "accepted item left no result")
	`LKXC_ASSERT_NEXT(a_run_sticks, st_q == ST_RUN, st_q == ST_RUN, "key left the ready state")
	`LKXC_ASSERT_NEXT(a_last_to_run, (st_q == ST_STEP) && status.last_step && !restart, st_q == ST_RUN, "derivation did not finish")

endmodule

// ===== hw/rtl/lfsr_key_xor_cipher_top.sv =====
// ----------------------------------------------------------------------------
// lfsr_key_xor_cipher_top
// Byte stream XOR cipher keyed by a 32-bit word from a Fibonacci LFSR.
//
//   channel  direction  handshake              payload
//   input    in         in_valid / in_stall    data_in   [7:0]
//   output   out        out_valid / out_stall  data_out  [7:0]
//   config   in         cfg_we                 cfg_index [1:0], cfg_data [31:0]
//
// The first item after reset stalls while the key is derived: the wait state that sees it,
// the load state, then the LFSR steps until the step counter reaches 2^degree - 1.
// After that one item is taken every cycle while the output register has room, and its
// result is shown on the output in the cycle after it is taken.
// Reset does not clear the key but forces a new derivation, using the taps and seed then held.
// A stalled output blocks new items only while its register is full.
// ----------------------------------------------------------------------------
module lfsr_key_xor_cipher_top #(
	parameter int LFSR_WIDTH = lkxc_pkg::LFSR_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [lkxc_pkg::DATA_W-1:0]     data_in,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [lkxc_pkg::DATA_W-1:0]     data_out,
	input  logic                            cfg_we,
	input  logic [lkxc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lkxc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lkxc_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	lkxc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cmd       (cmd),
		.status    (status)
	);

	lkxc_dp #(
		.LFSR_WIDTH (LFSR_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.data_in   (data_in),
		.data_out  (data_out)
	);

endmodule
